// File: rtl/mrsp_pkg.sv
// Shared types and constants for the MIDI running status parser.
package mrsp_pkg;

  // Kind of a reported event, carried in the output tuser.
  typedef enum logic [2:0] {
    EV_CLOCK    = 3'd0,
    EV_START    = 3'd1,
    EV_STOP     = 3'd2,
    EV_CC       = 3'd3,
    EV_NOTE_ON  = 3'd4,
    EV_NOTE_OFF = 3'd5
  } event_kind_e;

  // Configuration register indexes.
  localparam int CfgIdxW = 1;
  typedef enum logic [CfgIdxW-1:0] {
    CFG_CLOCKS_PER_BEAT = 1'b0,
    CFG_MODE_THRESHOLD  = 1'b1
  } cfg_idx_e;

  localparam int CfgDataW = 8;

  // Register reset values.
  localparam logic [6:0] CpbReset = 7'd24;
  localparam logic [7:0] ThrReset = 8'd120;

  // Real-time bytes of interest; everything at or above RtBase is real-time.
  localparam logic [7:0] RtBase    = 8'hF8;
  localparam logic [7:0] RtClock   = 8'hF8;
  localparam logic [7:0] RtStart   = 8'hFA;
  localparam logic [7:0] RtStop    = 8'hFC;

  // Status high nibbles.
  localparam logic [3:0] NibNoteOff  = 4'h8;
  localparam logic [3:0] NibNoteOn   = 4'h9;
  localparam logic [3:0] NibCtrl     = 4'hB;
  localparam logic [3:0] NibProgram  = 4'hC;
  localparam logic [3:0] NibChPress  = 4'hD;

  // Expected data bytes per message.
  localparam logic [1:0] LenNone = 2'd0;
  localparam logic [1:0] LenOne  = 2'd1;
  localparam logic [1:0] LenTwo  = 2'd2;

  // Status of the beat counter toward the parser.
  typedef struct packed {
    logic busy;   // counter is being reduced after a new beat length
    logic beat;   // the next clock item begins a beat
  } beat_stat_t;

endpackage

// File: rtl/mrsp_beat.sv
// Beat counter for MIDI clock items, with a short reduction pass after a length change.
module mrsp_beat
  import mrsp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cpb_we_i,
  input  logic [6:0] cpb_data_i,
  input  logic       clock_evt_i,
  output beat_stat_t stat_o
);

  logic [6:0] cpb_q;
  logic [6:0] cnt_q;     // raw counter as the last clock left it
  logic [6:0] red_q;     // counter reduced modulo the beat length
  logic [2:0] step_q;
  logic       busy_q;

  logic [6:0]  cpb_eff;
  logic [13:0] trial;
  logic [6:0]  red_inc;

  // A zero beat length behaves as one.
  assign cpb_eff = (cpb_q == 7'd0) ? 7'd1 : cpb_q;
  assign trial   = {7'd0, cpb_eff} << step_q;
  assign red_inc = red_q + 7'd1;

  // Restoring reduction, one shifted divisor per cycle, then clock counting.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cpb_q  <= CpbReset;
      cnt_q  <= 7'd0;
      red_q  <= 7'd0;
      step_q <= 3'd0;
      busy_q <= 1'b0;
    end else if (cpb_we_i) begin
      cpb_q  <= cpb_data_i;
      red_q  <= cnt_q;
      step_q <= 3'd6;
      busy_q <= 1'b1;
    end else if (busy_q) begin
      if ({7'd0, red_q} >= trial) begin
        red_q <= red_q - trial[6:0];
      end
      if (step_q == 3'd0) begin
        busy_q <= 1'b0;
      end else begin
        step_q <= step_q - 3'd1;
      end
    end else if (clock_evt_i) begin
      cnt_q <= red_inc;
      red_q <= (red_inc == cpb_eff) ? 7'd0 : red_inc;
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.beat = (red_q == 7'd0);

  // The reduced counter stays below the beat length whenever it is in use.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> (red_q < cpb_eff))
    else $error("beat counter out of range");

  // A new beat length always starts a reduction pass.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cpb_we_i |=> busy_q)
    else $error("reduction did not start");

  // The pass ends after its last step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && step_q == 3'd0 && !cpb_we_i) |=> !busy_q)
    else $error("reduction did not finish");

  // No clock item is counted during the pass.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && clock_evt_i && !cpb_we_i) |=> $stable(cnt_q))
    else $error("clock counted while reducing");

endmodule

// File: rtl/midi_running_status_parser.sv
// Top level of the MIDI running status parser: byte decode, message state, result register.
// A result is registered and appears on the output in the cycle after its byte is accepted.
// Throughput: one byte per cycle while the receiver takes results and the beat counter is settled;
// the output register takes a new item as the old one leaves. After a write of clocks_per_beat
// the input stalls while the beat counter is reduced to the new length (one shifted subtract per cycle).
// Reset clears running status, data count, held byte, beat counter and the output valid.
module midi_running_status_parser
  import mrsp_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [7:0]          s_axis_tdata,   // [7:0] rx_byte
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [23:0]         m_axis_tdata,   // [0] beat_pulse, [4:1] channel,
                                              // [11:5] first_value, [18:12] second_value
  output logic [2:0]          m_axis_tuser,   // [2:0] event_kind
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  logic [7:0] status_q;
  logic [1:0] didx_q, didx_d;
  logic [1:0] mlen_q, mlen_d;
  logic [6:0] held_q, held_d;
  logic [7:0] thr_q;

  logic        out_valid_q;
  event_kind_e out_kind_q;
  logic        out_beat_q;
  logic [3:0]  out_chan_q;
  logic [6:0]  out_v1_q;
  logic [6:0]  out_v2_q;

  logic        ev_valid;
  event_kind_e ev_kind;
  logic        ev_beat;
  logic [3:0]  ev_chan;
  logic [6:0]  ev_v1;
  logic [6:0]  ev_v2;
  logic [7:0]  status_d;

  logic       accept;
  logic       cpb_we;
  logic       clock_evt;
  logic       idx;
  beat_stat_t beat_stat;
  logic [7:0] b;

  assign b      = s_axis_tdata;
  assign cpb_we = cfg_we_i && (cfg_idx_i == CFG_CLOCKS_PER_BEAT);

  // Take a byte when the result register is free or draining and the counter is settled and not being rewritten.
  assign s_axis_tready = !beat_stat.busy && !cpb_we && (!out_valid_q || m_axis_tready);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign clock_evt     = accept && (b == RtClock);

  mrsp_beat u_beat (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cpb_we_i   (cpb_we),
    .cpb_data_i (cfg_data_i[6:0]),
    .clock_evt_i(clock_evt),
    .stat_o     (beat_stat)
  );

  // Position of this data byte within its message.
  assign idx = (mlen_q == LenTwo) && didx_q[0];

  // Decode one byte against the message state.
  always_comb begin
    ev_valid = 1'b0;
    ev_kind  = EV_CLOCK;
    ev_beat  = 1'b0;
    ev_chan  = 4'd0;
    ev_v1    = 7'd0;
    ev_v2    = 7'd0;
    status_d = status_q;
    didx_d   = didx_q;
    mlen_d   = mlen_q;
    held_d   = held_q;
    if (b[7]) begin
      if (b >= RtBase) begin
        case (b)
          RtClock: begin
            ev_valid = 1'b1;
            ev_kind  = EV_CLOCK;
            ev_beat  = beat_stat.beat;
          end
          RtStart: begin
            ev_valid = 1'b1;
            ev_kind  = EV_START;
          end
          RtStop: begin
            ev_valid = 1'b1;
            ev_kind  = EV_STOP;
          end
          default: ev_valid = 1'b0;
        endcase
      end else begin
        status_d = b;
        didx_d   = 2'd0;
        mlen_d   = (b[7:4] == NibProgram || b[7:4] == NibChPress) ? LenOne : LenTwo;
      end
    end else if (mlen_q != LenNone) begin
      if (!idx) begin
        held_d = b[6:0];
      end
      didx_d = {1'b0, idx} + 2'd1;
      if (idx) begin
        ev_chan = status_q[3:0];
        ev_v1   = held_q;
        ev_v2   = b[6:0];
        case (status_q[7:4])
          NibCtrl: begin
            ev_valid = ({1'b0, held_q} < thr_q);
            ev_kind  = EV_CC;
          end
          NibNoteOn: begin
            ev_valid = 1'b1;
            ev_kind  = EV_NOTE_ON;
          end
          NibNoteOff: begin
            ev_valid = 1'b1;
            ev_kind  = EV_NOTE_OFF;
          end
          default: ev_valid = 1'b0;
        endcase
      end
    end
  end

  // Message state and threshold register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_q <= 8'd0;
      didx_q   <= 2'd0;
      mlen_q   <= LenNone;
      held_q   <= 7'd0;
      thr_q    <= ThrReset;
    end else begin
      if (cfg_we_i && cfg_idx_i == CFG_MODE_THRESHOLD) begin
        thr_q <= cfg_data_i;
      end
      if (accept) begin
        status_q <= status_d;
        didx_q   <= didx_d;
        mlen_q   <= mlen_d;
        held_q   <= held_d;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= ev_valid;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_kind_q <= ev_kind;
      out_beat_q <= ev_beat;
      out_chan_q <= ev_chan;
      out_v1_q   <= ev_v1;
      out_v2_q   <= ev_v2;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tdata  = {5'd0, out_v2_q, out_v1_q, out_chan_q, out_beat_q};

endmodule

// File: tb/sv/midi_running_status_parser_test.sv
// Self-checking testbench for the MIDI running status parser: byte stream in, event items out.
module midi_running_status_parser_test;
  timeunit 1ns;
  timeprecision 1ps;
  import mrsp_pkg::*;

  // Status nibbles that the package leaves unnamed.
  localparam logic [3:0] NibPolyPress = 4'hA;
  localparam logic [3:0] NibPitchBend = 4'hE;
  localparam logic [3:0] NibSystem    = 4'hF;

  localparam int PhaseCount  = 6;
  localparam int PhaseItems  = 155;
  localparam int SettleTicks = 4;
  localparam int CycleLimit  = 200000;
  localparam int ReportLimit = 10;

  // One reported event as the checker sees it.
  typedef struct packed {
    logic [2:0] kind;
    logic       beat;
    logic [3:0] chan;
    logic [6:0] first_value;
    logic [6:0] second_value;
  } midi_event_t;

  // Tracks the parser state, predicts the events of each accepted byte and checks results.
  class midi_event_board;
    logic [6:0]  clocks_per_beat;
    logic [7:0]  mode_threshold;
    logic [7:0]  running_status;
    int          data_index;
    int          message_length;
    logic [6:0]  held_first;
    logic [6:0]  beat_count;
    midi_event_t expected_q[$];
    int          errors;

    function new();
      clocks_per_beat = CpbReset;
      mode_threshold  = ThrReset;
      running_status  = '0;
      data_index      = 0;
      message_length  = 0;
      held_first      = '0;
      beat_count      = '0;
      errors          = 0;
    endfunction

    function void set_register(cfg_idx_e idx, logic [7:0] value);
      if (idx == CFG_CLOCKS_PER_BEAT) begin
        clocks_per_beat = value[6:0];
      end else begin
        mode_threshold = value;
      end
    endfunction

    function void push_event(event_kind_e kind, logic beat, logic [3:0] chan,
                             logic [6:0] first_value, logic [6:0] second_value);
      midi_event_t ev;
      ev.kind         = kind;
      ev.beat         = beat;
      ev.chan         = chan;
      ev.first_value  = first_value;
      ev.second_value = second_value;
      expected_q.push_back(ev);
    endfunction

    // Predict what one accepted byte reports, and advance the parser state.
    function void note_byte(logic [7:0] b);
      int period;
      int phase;
      int idx;
      if (b[7]) begin
        if (b >= RtBase) begin
          // Real-time bytes never touch the message being assembled.
          if (b == RtClock) begin
            period = (clocks_per_beat == 0) ? 1 : int'(clocks_per_beat);
            phase = int'(beat_count) % period;
            push_event(EV_CLOCK, phase == 0, '0, '0, '0);
            beat_count = 7'(phase + 1);
          end else if (b == RtStart) begin
            push_event(EV_START, 1'b0, '0, '0, '0);
          end else if (b == RtStop) begin
            push_event(EV_STOP, 1'b0, '0, '0, '0);
          end
          return;
        end
        running_status = b;
        data_index = 0;
        message_length = (b[7:4] == NibProgram || b[7:4] == NibChPress) ? 1 : 2;
        return;
      end
      // Data bytes before any status byte are dropped.
      if (message_length == 0) return;
      idx = data_index % message_length;
      if (idx == 0) held_first = b[6:0];
      idx++;
      data_index = idx & 3;
      if (idx != message_length || message_length != 2) return;
      case (running_status[7:4])
        NibCtrl: begin
          if ({1'b0, held_first} < mode_threshold) begin
            push_event(EV_CC, 1'b0, running_status[3:0], held_first, b[6:0]);
          end
        end
        NibNoteOn: begin
          push_event(EV_NOTE_ON, 1'b0, running_status[3:0], held_first, b[6:0]);
        end
        NibNoteOff: begin
          push_event(EV_NOTE_OFF, 1'b0, running_status[3:0], held_first, b[6:0]);
        end
        default: begin
        end
      endcase
    endfunction

    function string show(midi_event_t ev);
      return $sformatf("kind %0d beat %0d chan %0d first %0d second %0d",
                       ev.kind, ev.beat, ev.chan, ev.first_value, ev.second_value);
    endfunction

    function void note_failure(string what);
      errors++;
      if (errors <= ReportLimit) $display("mismatch: %s", what);
    endfunction

    // Compare one accepted result with the oldest prediction.
    function void check_event(logic [2:0] kind, logic [23:0] data);
      midi_event_t got;
      midi_event_t want;
      got.kind         = kind;
      got.beat         = data[0];
      got.chan         = data[4:1];
      got.first_value  = data[11:5];
      got.second_value = data[18:12];
      if (expected_q.size() == 0) begin
        note_failure($sformatf("unexpected item, got %s", show(got)));
        return;
      end
      want = expected_q.pop_front();
      if (got.kind != want.kind || got.beat != want.beat || got.chan != want.chan ||
          got.first_value != want.first_value || got.second_value != want.second_value) begin
        note_failure($sformatf("expected %s, got %s", show(want), show(got)));
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Any prediction still waiting at the end is a failure.
    function void close();
      while (expected_q.size() != 0) begin
        note_failure($sformatf("missing item, expected %s", show(expected_q.pop_front())));
      end
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata = '0;   // [7:0] rx_byte
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [23:0]         m_axis_tdata;        // [0] beat_pulse, [4:1] channel,
                                            // [11:5] first_value, [18:12] second_value
  logic [2:0]          m_axis_tuser;        // [2:0] event_kind
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = CFG_CLOCKS_PER_BEAT;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  midi_event_board board;
  int              items_sent = 0;
  int              burst_left = 0;
  bit              sender_steady = 1'b0;
  logic [7:0]      cur_status = '0;
  logic [7:0]      cur_thr = ThrReset;
  int              cycle_count = 0;
  int              ready_left = 0;
  int              ready_mode = 0;
  logic [7:0]      ready_mask = 8'hFF;
  logic [2:0]      ready_phase = '0;

  // Opening sequence: stray data, every real-time byte, note on and off with running status,
  // zero velocity, a clock inside a message, control change on both sides of the threshold,
  // program change and a system common status.
  logic [7:0] opening_bytes[$] = '{
    8'h00, 8'hF8, 8'hFA, 8'hFC, 8'hF9, 8'hFB, 8'hFD, 8'hFE, 8'hFF,
    8'h9F, 8'h00, 8'h7F, 8'h7F, 8'h00,
    8'h80, 8'h7F, 8'hF8, 8'h40,
    8'hB5, 8'h77, 8'h7F, 8'h78, 8'h00,
    8'hC1, 8'h10, 8'hF3, 8'h01, 8'h02
  };

  midi_running_status_parser DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  // Clock.
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Guard against a hung run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  // Check every result item accepted at this edge.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      board.check_event(m_axis_tuser, m_axis_tdata);
    end
  end

  // Receiver backpressure: stretches at full speed mix at random with stretches under a repeating stall mask.
  always @(negedge clk_i) begin
    if (ready_left == 0) begin
      ready_left = $urandom_range(16, 80);
      ready_mode = $urandom_range(0, 1);
      ready_mask = 8'($urandom_range(1, 255));
    end
    ready_left--;
    ready_phase++;
    m_axis_tready = (ready_mode == 0) ? 1'b1 : ready_mask[ready_phase];
  end

  // Offer one byte, called at a falling edge; returns at the falling edge after acceptance.
  task automatic put_byte(logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = sender_steady ? 0 : $urandom_range(0, 6);
      if (gap != 0) begin
        s_axis_tvalid = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = b;
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_byte(b);
    items_sent++;
    @(negedge clk_i);
  endtask

  // Hold off the sender until every predicted item has come out, then let the block settle.
  task automatic drain_results();
    s_axis_tvalid = 1'b0;
    burst_left = 0;
    while (board.pending() != 0) @(negedge clk_i);
    repeat (SettleTicks) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [7:0] value);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = value;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    board.set_register(idx, value);
    if (idx == CFG_MODE_THRESHOLD) cur_thr = value;
  endtask

  // One message with random content; now and then noise, a real-time byte or a cut-off message.
  task automatic send_message();
    int         r;
    int         len;
    int         i;
    logic [3:0] nib;
    logic [7:0] d;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      put_byte(8'($urandom_range(0, 255)));
      return;
    end
    // Most messages carry a fresh status; the rest lean on running status.
    if (r < 70 || cur_status == 0) begin
      r = $urandom_range(0, 99);
      nib = (r < 30) ? NibNoteOn : (r < 50) ? NibNoteOff : (r < 75) ? NibCtrl :
            (r < 82) ? NibProgram : (r < 88) ? NibChPress : (r < 93) ? NibPolyPress :
            (r < 97) ? NibPitchBend : NibSystem;
      cur_status = (nib == NibSystem) ? {nib, 1'b0, 3'($urandom_range(0, 7))}
                                      : {nib, 4'($urandom_range(0, 15))};
      put_byte(cur_status);
    end
    len = (cur_status[7:4] == NibProgram || cur_status[7:4] == NibChPress) ? 1 : 2;
    for (i = 0; i < len; i++) begin
      if ($urandom_range(0, 9) == 0) put_byte(8'($urandom_range(248, 255)));
      if ($urandom_range(0, 39) == 0) return;
      d = {1'b0, 7'($urandom_range(0, 127))};
      // Aim controller numbers at the mode threshold now and then.
      if (i == 0 && cur_status[7:4] == NibCtrl && $urandom_range(0, 2) == 0) begin
        if (cur_thr == 0) begin
          d = 8'd0;
        end else if (cur_thr > 8'd127) begin
          d = 8'd127;
        end else begin
          d = cur_thr - 8'($urandom_range(0, 1));
        end
      end
      put_byte(d);
    end
    if ($urandom_range(0, 199) == 0) drain_results();
  endtask

  // Main sequence: reset, opening bytes, then random phases under changing settings.
  initial begin
    int phase;
    int target;
    board = new();
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    foreach (opening_bytes[k]) put_byte(opening_bytes[k]);
    target = items_sent;
    for (phase = 0; phase < PhaseCount; phase++) begin
      drain_results();
      case (phase)
        1: begin
          write_reg(CFG_CLOCKS_PER_BEAT, 8'd1);
          write_reg(CFG_MODE_THRESHOLD, 8'd0);
        end
        2: begin
          write_reg(CFG_CLOCKS_PER_BEAT, 8'd127);
          write_reg(CFG_MODE_THRESHOLD, 8'd128);
        end
        3: begin
          write_reg(CFG_CLOCKS_PER_BEAT, 8'd0);
          write_reg(CFG_MODE_THRESHOLD, 8'($urandom_range(1, 127)));
        end
        4: begin
          write_reg(CFG_CLOCKS_PER_BEAT, 8'($urandom_range(2, 40)));
          write_reg(CFG_MODE_THRESHOLD, ThrReset);
        end
        5: begin
          write_reg(CFG_MODE_THRESHOLD, 8'($urandom_range(0, 128)));
          write_reg(CFG_CLOCKS_PER_BEAT, 8'($urandom_range(1, 127)));
        end
        default: begin
        end
      endcase
      sender_steady = ($urandom_range(0, 3) == 0);
      target += PhaseItems;
      while (items_sent < target) send_message();
    end
    drain_results();
    repeat (8) @(negedge clk_i);
    board.close();
    if (board.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
